>>> rtl/bds_pkg.sv
// ----------------------------------------------------------------------------
// bds_pkg
// Shared types and constants of the brush dab spacer: datapath commands,
// status bundle, register indexes and fixed internal widths.
// ----------------------------------------------------------------------------
package bds_pkg;

  // fixed widths
  localparam int CfgW  = 20;   // config data, widest register
  localparam int IdxW  = 3;    // config register index
  localparam int NumW  = 36;   // divider dividend / quotient
  localparam int DenW  = 20;   // divider divisor / remainder
  localparam int RadW  = 33;   // squared segment length
  localparam int DistW = 17;   // segment length
  localparam int SpcW  = 18;   // spacing, leftover, distance along segment
  localparam int TotW  = 33;   // travelled plus distance along segment
  localparam int NW    = 12;   // dab count of one segment

  // config register indexes
  localparam logic [IdxW-1:0] REG_BRUSH_SIZE    = 3'd0;
  localparam logic [IdxW-1:0] REG_SPACING_FRAC  = 3'd1;
  localparam logic [IdxW-1:0] REG_BASE_OPACITY  = 3'd2;
  localparam logic [IdxW-1:0] REG_TAPER_LEN     = 3'd3;
  localparam logic [IdxW-1:0] REG_FALLOFF_LEN   = 3'd4;
  localparam logic [IdxW-1:0] REG_SIZE_BY_PRES  = 3'd5;
  localparam logic [IdxW-1:0] REG_OPAC_BY_PRES  = 3'd6;

  localparam logic [SpcW-1:0] MIN_SPACING = 18'd32;
  localparam logic [SpcW-1:0] NEGL_LEFT   = 18'd2;
  localparam logic [8:0]      PRES_ONE    = 9'd256;

  // datapath commands
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LATCH,
    DP_BEGIN,
    DP_SQUARE,
    DP_ROOT,
    DP_ROOT_WAIT,
    DP_C0,
    DP_DIV_N,
    DP_WAIT_N,
    DP_TOTAL,
    DP_DIV_X,
    DP_WAIT_X,
    DP_DIV_Y,
    DP_WAIT_Y,
    DP_DIV_T,
    DP_WAIT_T,
    DP_DIV_F,
    DP_WAIT_F,
    DP_EMIT,
    DP_FIN
  } dp_cmd_t;

  // datapath status
  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic is_begin;
    logic negligible;
    logic n_zero;
    logic last_dab;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/bds_div.sv
// ----------------------------------------------------------------------------
// bds_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bds_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bds_pkg::NumW-1:0]   num,
  input  logic [bds_pkg::DenW-1:0]   den,
  output logic                       done,
  output logic [bds_pkg::NumW-1:0]   quo,
  output logic [bds_pkg::DenW-1:0]   rem
);

  localparam int CntW = $clog2(bds_pkg::NumW);

  logic [bds_pkg::NumW-1:0] qreg;
  logic [bds_pkg::DenW-1:0] acc;
  logic [bds_pkg::DenW-1:0] dreg;
  logic [CntW-1:0]          cnt;
  logic                     busy;
  logic [bds_pkg::DenW:0]   trial;
  logic                     ge;

  // one restoring step
  assign trial = {acc, qreg[bds_pkg::NumW-1]};
  assign ge    = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        qreg <= num;
        dreg <= den;
        acc  <= '0;
        cnt  <= CntW'(bds_pkg::NumW - 1);
      end else if (busy) begin
        acc  <= ge ? bds_pkg::DenW'(trial - {1'b0, dreg}) : trial[bds_pkg::DenW-1:0];
        qreg <= {qreg[bds_pkg::NumW-2:0], ge};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign quo = qreg;
  assign rem = acc;

endmodule

>>> rtl/bds_sqrt.sv
// ----------------------------------------------------------------------------
// bds_sqrt
// Digit-by-digit square root, two radicand bits per cycle, rounded to nearest.
// ----------------------------------------------------------------------------
module bds_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bds_pkg::RadW-1:0]    radicand,
  output logic                        done,
  output logic [bds_pkg::DistW-1:0]   root
);

  logic [2*bds_pkg::DistW-1:0] rad;
  logic [bds_pkg::DistW+1:0]   rem;
  logic [bds_pkg::DistW-1:0]   rt;
  logic [4:0]                  cnt;
  logic                        busy;
  logic [bds_pkg::DistW+3:0]   r4;
  logic [bds_pkg::DistW+3:0]   trial;
  logic                        ge;

  // bring down two bits, try root*4+1
  assign r4    = {rem, rad[2*bds_pkg::DistW-1 -: 2]};
  assign trial = {2'b00, rt, 2'b01};
  assign ge    = r4 >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rad  <= {1'b0, radicand};
        rem  <= '0;
        rt   <= '0;
        cnt  <= 5'(bds_pkg::DistW - 1);
      end else if (busy) begin
        rad <= {rad[2*bds_pkg::DistW-3:0], 2'b00};
        rem <= ge ? (bds_pkg::DistW+2)'(r4 - trial) : r4[bds_pkg::DistW+1:0];
        rt  <= {rt[bds_pkg::DistW-2:0], ge};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // round up when the remainder exceeds the floor root
  assign root = rt + bds_pkg::DistW'(rem > {2'b00, rt});

endmodule

>>> rtl/bds_dp.sv
// ----------------------------------------------------------------------------
// bds_dp
// Datapath: config registers, stroke state, segment setup, per-dab
// interpolation, taper and falloff, and the output word register.
// ----------------------------------------------------------------------------
module bds_dp #(
  parameter int MAX_DABS   = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bds_pkg::dp_cmd_t            cmd,
  output bds_pkg::dp_stat_t           stat,
  input  logic                        cfg_we,
  input  logic [bds_pkg::IdxW-1:0]    cfg_index,
  input  logic [bds_pkg::CfgW-1:0]    cfg_data,
  input  logic                        mode,
  input  logic [15:0]                 pen_x,
  input  logic [15:0]                 pen_y,
  input  logic [8:0]                  pen_pressure,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [15:0]                 dab_x,
  output logic [15:0]                 dab_y,
  output logic [15:0]                 dab_size,
  output logic [7:0]                  dab_opacity,
  output logic                        last_dab,
  output logic                        truncated
);

  localparam int KW = $clog2(MAX_DABS + 1);
  localparam logic [15:0] CoordMask =
    (COORD_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << COORD_BITS) - 32'd1);

  // config registers
  logic [15:0] brush_size;
  logic [9:0]  spacing_fraction;
  logic [7:0]  base_opacity;
  logic [19:0] taper_start_len;
  logic [19:0] falloff_len;
  logic        size_by_pressure;
  logic        opacity_by_pressure;

  // stroke state
  logic [15:0]              last_x;
  logic [15:0]              last_y;
  logic [bds_pkg::SpcW-1:0] leftover_dist;
  logic                     stroke_fresh;
  logic [31:0]              travelled;

  // item and segment registers
  logic                      mode_r;
  logic [15:0]               px;
  logic [15:0]               py;
  logic [8:0]                pres;
  logic [15:0]               dx;
  logic [15:0]               dy;
  logic                      xneg;
  logic                      yneg;
  logic [31:0]               dx2;
  logic [31:0]               dy2;
  logic [15:0]               size;
  logic [7:0]                opac;
  logic [bds_pkg::SpcW-1:0]  spacing;
  logic [bds_pkg::DistW-1:0] seg_dist;
  logic [bds_pkg::SpcW-1:0]  c0;
  logic [bds_pkg::SpcW-1:0]  newleft;
  logic                      trunc;
  logic [KW-1:0]             emit;
  logic [KW-1:0]             k;
  logic [bds_pkg::SpcW-1:0]  c;
  logic [bds_pkg::TotW-1:0]  total;
  logic [15:0]               ox;
  logic [15:0]               oy;
  logic [15:0]               osize;
  logic [7:0]                oop;

  // combinational helpers
  logic [15:0]               mx;
  logic [15:0]               my;
  logic [8:0]                psat;
  logic [24:0]               size_prod;
  logic [16:0]               opac_prod;
  logic [25:0]               spc_prod;
  logic [bds_pkg::SpcW-1:0]  spc_raw;
  logic [bds_pkg::NW-1:0]    n;
  logic [32:0]               trav_sum;
  logic                      taper_on;
  logic                      fall_before;

  // shared units
  logic                        sqrt_start;
  logic                        sqrt_done;
  logic [bds_pkg::DistW-1:0]   sqrt_root;
  logic                        div_start;
  logic [bds_pkg::NumW-1:0]    div_num;
  logic [bds_pkg::DenW-1:0]    div_den;
  logic                        div_done;
  logic [bds_pkg::NumW-1:0]    div_quo;
  logic [bds_pkg::DenW-1:0]    div_rem;

  bds_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand ({1'b0, dx2} + {1'b0, dy2}),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  bds_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  // input conditioning
  assign mx   = pen_x & CoordMask;
  assign my   = pen_y & CoordMask;
  assign psat = (pen_pressure > bds_pkg::PRES_ONE) ? bds_pkg::PRES_ONE : pen_pressure;

  // pressure and spacing products
  assign size_prod = {9'd0, brush_size} * {16'd0, pres};
  assign opac_prod = {9'd0, base_opacity} * {8'd0, pres};
  assign spc_prod  = {10'd0, size} * {16'd0, spacing_fraction};
  assign spc_raw   = spc_prod[25:8];

  assign n           = div_quo[bds_pkg::NW-1:0] + 1'b1;
  assign trav_sum    = {1'b0, travelled} + {15'd0, seg_dist};
  assign taper_on    = (taper_start_len != '0) && (total < {13'd0, taper_start_len});
  assign fall_before = total < {13'd0, falloff_len};

  // unit start and operand selection
  always_comb begin
    sqrt_start = cmd == bds_pkg::DP_ROOT;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    case (cmd)
      bds_pkg::DP_DIV_N: begin
        div_start = 1'b1;
        div_num   = bds_pkg::NumW'({1'b0, seg_dist} - c0);
        div_den   = bds_pkg::DenW'(spacing);
      end
      bds_pkg::DP_DIV_X: begin
        div_start = 1'b1;
        div_num   = {({18'd0, dx} * {16'd0, c}), 1'b0} + bds_pkg::NumW'(seg_dist);
        div_den   = bds_pkg::DenW'({seg_dist, 1'b0});
      end
      bds_pkg::DP_DIV_Y: begin
        div_start = 1'b1;
        div_num   = {({18'd0, dy} * {16'd0, c}), 1'b0} + bds_pkg::NumW'(seg_dist);
        div_den   = bds_pkg::DenW'({seg_dist, 1'b0});
      end
      bds_pkg::DP_DIV_T: begin
        div_start = 1'b1;
        div_num   = {20'd0, size} * {16'd0, total[19:0]};
        div_den   = taper_start_len;
      end
      bds_pkg::DP_DIV_F: begin
        div_start = 1'b1;
        div_num   = bds_pkg::NumW'({20'd0, opac} * {8'd0, falloff_len - total[19:0]});
        div_den   = falloff_len;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      brush_size          <= 16'd160;
      spacing_fraction    <= 10'd26;
      base_opacity        <= 8'd255;
      taper_start_len     <= '0;
      falloff_len         <= '0;
      size_by_pressure    <= 1'b1;
      opacity_by_pressure <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bds_pkg::REG_BRUSH_SIZE:   brush_size          <= cfg_data[15:0];
        bds_pkg::REG_SPACING_FRAC: spacing_fraction    <= cfg_data[9:0];
        bds_pkg::REG_BASE_OPACITY: base_opacity        <= cfg_data[7:0];
        bds_pkg::REG_TAPER_LEN:    taper_start_len     <= cfg_data;
        bds_pkg::REG_FALLOFF_LEN:  falloff_len         <= cfg_data;
        bds_pkg::REG_SIZE_BY_PRES: size_by_pressure    <= cfg_data[0];
        bds_pkg::REG_OPAC_BY_PRES: opacity_by_pressure <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stroke state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_x        <= '0;
      last_y        <= '0;
      leftover_dist <= '0;
      stroke_fresh  <= 1'b1;
      travelled     <= '0;
    end else if (cmd == bds_pkg::DP_BEGIN) begin
      last_x        <= px;
      last_y        <= py;
      leftover_dist <= '0;
      stroke_fresh  <= 1'b1;
      travelled     <= '0;
    end else if (cmd == bds_pkg::DP_FIN) begin
      last_x        <= px;
      last_y        <= py;
      leftover_dist <= newleft;
      stroke_fresh  <= 1'b0;
      travelled     <= trav_sum[32] ? 32'hFFFF_FFFF : trav_sum[31:0];
    end
  end

  // segment and dab arithmetic
  always_ff @(posedge clk) begin
    case (cmd)
      bds_pkg::DP_LATCH: begin
        mode_r <= mode;
        px     <= mx;
        py     <= my;
        pres   <= psat;
        xneg   <= mx < last_x;
        yneg   <= my < last_y;
        dx     <= (mx >= last_x) ? mx - last_x : last_x - mx;
        dy     <= (my >= last_y) ? my - last_y : last_y - my;
      end
      bds_pkg::DP_SQUARE: begin
        dx2  <= {16'd0, dx} * {16'd0, dx};
        dy2  <= {16'd0, dy} * {16'd0, dy};
        size <= size_by_pressure ? size_prod[23:8] : brush_size;
        opac <= opacity_by_pressure ? opac_prod[15:8] : base_opacity;
      end
      bds_pkg::DP_ROOT: begin
        spacing <= (spc_raw < bds_pkg::MIN_SPACING) ? bds_pkg::MIN_SPACING : spc_raw;
      end
      bds_pkg::DP_ROOT_WAIT: begin
        if (sqrt_done) seg_dist <= sqrt_root;
      end
      bds_pkg::DP_C0: begin
        c0      <= (stroke_fresh || leftover_dist >= spacing) ? '0 : spacing - leftover_dist;
        newleft <= bds_pkg::SpcW'(leftover_dist + {1'b0, seg_dist});
      end
      bds_pkg::DP_WAIT_N: begin
        if (div_done) begin
          trunc   <= n > bds_pkg::NW'(MAX_DABS);
          emit    <= (n > bds_pkg::NW'(MAX_DABS)) ? KW'(MAX_DABS) : KW'(n);
          newleft <= div_rem[bds_pkg::SpcW-1:0];
          k       <= '0;
          c       <= c0;
        end
      end
      bds_pkg::DP_TOTAL: begin
        total <= {1'b0, travelled} + {15'd0, c};
      end
      bds_pkg::DP_WAIT_X: begin
        if (div_done)
          ox <= (seg_dist == '0) ? last_x
              : (xneg ? last_x - div_quo[15:0] : last_x + div_quo[15:0]);
      end
      bds_pkg::DP_WAIT_Y: begin
        if (div_done)
          oy <= (seg_dist == '0) ? last_y
              : (yneg ? last_y - div_quo[15:0] : last_y + div_quo[15:0]);
      end
      bds_pkg::DP_WAIT_T: begin
        if (div_done) osize <= taper_on ? div_quo[15:0] : size;
      end
      bds_pkg::DP_WAIT_F: begin
        if (div_done)
          oop <= (falloff_len == '0) ? opac : (fall_before ? div_quo[7:0] : 8'd0);
      end
      bds_pkg::DP_EMIT: begin
        k <= k + 1'b1;
        c <= c + spacing;
      end
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == bds_pkg::DP_EMIT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == bds_pkg::DP_EMIT) begin
      dab_x       <= ox;
      dab_y       <= oy;
      dab_size    <= osize;
      dab_opacity <= oop;
      last_dab    <= (k + 1'b1) == emit;
      truncated   <= trunc;
    end
  end

  // status to the controller
  assign stat.sqrt_done  = sqrt_done;
  assign stat.div_done   = div_done;
  assign stat.is_begin   = !mode_r;
  assign stat.negligible = (seg_dist == '0) && !stroke_fresh &&
                           (leftover_dist >= bds_pkg::NEGL_LEFT);
  assign stat.n_zero     = c0 > {1'b0, seg_dist};
  assign stat.last_dab   = (k + 1'b1) == emit;
  assign stat.out_free   = !out_valid || !out_stall;

endmodule

>>> rtl/bds_ctrl.sv
// ----------------------------------------------------------------------------
// bds_ctrl
// Controller: sequences segment setup, the dab loop and the state update.
// ----------------------------------------------------------------------------
module bds_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bds_pkg::dp_stat_t  stat,
  output bds_pkg::dp_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_ROOT, S_ROOT_WAIT, S_C0, S_NCHK, S_WAITN,
    S_TOTAL, S_DIVX, S_WAITX, S_DIVY, S_WAITY, S_DIVT, S_WAITT,
    S_DIVF, S_WAITF, S_EMIT, S_FIN
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = state != S_IDLE;

  // next state and command
  always_comb begin
    state_next = state;
    cmd        = bds_pkg::DP_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = bds_pkg::DP_LATCH;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (stat.is_begin) begin
          cmd        = bds_pkg::DP_BEGIN;
          state_next = S_IDLE;
        end else begin
          cmd        = bds_pkg::DP_SQUARE;
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        cmd        = bds_pkg::DP_ROOT;
        state_next = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        cmd = bds_pkg::DP_ROOT_WAIT;
        if (stat.sqrt_done) state_next = S_C0;
      end
      S_C0: begin
        if (stat.negligible) begin
          state_next = S_IDLE;
        end else begin
          cmd        = bds_pkg::DP_C0;
          state_next = S_NCHK;
        end
      end
      S_NCHK: begin
        if (stat.n_zero) begin
          state_next = S_FIN;
        end else begin
          cmd        = bds_pkg::DP_DIV_N;
          state_next = S_WAITN;
        end
      end
      S_WAITN: begin
        cmd = bds_pkg::DP_WAIT_N;
        if (stat.div_done) state_next = S_TOTAL;
      end
      S_TOTAL: begin
        cmd        = bds_pkg::DP_TOTAL;
        state_next = S_DIVX;
      end
      S_DIVX: begin
        cmd        = bds_pkg::DP_DIV_X;
        state_next = S_WAITX;
      end
      S_WAITX: begin
        cmd = bds_pkg::DP_WAIT_X;
        if (stat.div_done) state_next = S_DIVY;
      end
      S_DIVY: begin
        cmd        = bds_pkg::DP_DIV_Y;
        state_next = S_WAITY;
      end
      S_WAITY: begin
        cmd = bds_pkg::DP_WAIT_Y;
        if (stat.div_done) state_next = S_DIVT;
      end
      S_DIVT: begin
        cmd        = bds_pkg::DP_DIV_T;
        state_next = S_WAITT;
      end
      S_WAITT: begin
        cmd = bds_pkg::DP_WAIT_T;
        if (stat.div_done) state_next = S_DIVF;
      end
      S_DIVF: begin
        cmd        = bds_pkg::DP_DIV_F;
        state_next = S_WAITF;
      end
      S_WAITF: begin
        cmd = bds_pkg::DP_WAIT_F;
        if (stat.div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd        = bds_pkg::DP_EMIT;
          state_next = stat.last_dab ? S_FIN : S_TOTAL;
        end
      end
      S_FIN: begin
        cmd        = bds_pkg::DP_FIN;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/brush_dab_spacer_unit.sv
// ----------------------------------------------------------------------------
// brush_dab_spacer_unit
// Places brush dabs at even spacing along pen segments.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes pen words: mode 0 begins a stroke,
// mode 1 draws a segment from the last point to the pen point. Each segment
// yields zero to MAX_DABS dab words on the output channel (out_valid/
// out_stall), the last one marked by last_dab.
// One pen word at a time: in_stall is high from acceptance until the
// controller is idle again, after its last dab sits in the output register.
// A move word runs setup (17-step square root) and the segment count
// division, then four divisions per dab, since the single 36-step divider
// is shared by the x, y, taper and falloff quotients.
// A word with no dabs finishes after setup.
// The output register lets the next pen word in while the last dab waits;
// a stalled receiver holds the dab and pauses the dab loop.
// Reset clears the stroke state to a fresh stroke at (0,0) and loads the
// default brush registers. Registers are written through cfg_we/cfg_index/
// cfg_data; the user writes them only while the block is idle, unenforced.
// ----------------------------------------------------------------------------
module brush_dab_spacer_unit #(
  parameter int MAX_DABS   = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bds_pkg::IdxW-1:0]   cfg_index,
  input  logic [bds_pkg::CfgW-1:0]   cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       mode,
  input  logic [15:0]                pen_x,
  input  logic [15:0]                pen_y,
  input  logic [8:0]                 pen_pressure,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [15:0]                dab_x,
  output logic [15:0]                dab_y,
  output logic [15:0]                dab_size,
  output logic [7:0]                 dab_opacity,
  output logic                       last_dab,
  output logic                       truncated
);

  bds_pkg::dp_cmd_t  cmd;
  bds_pkg::dp_stat_t stat;

  // sequencer
  bds_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  // arithmetic and state
  bds_dp #(
    .MAX_DABS  (MAX_DABS),
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mode        (mode),
    .pen_x       (pen_x),
    .pen_y       (pen_y),
    .pen_pressure(pen_pressure),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .dab_x       (dab_x),
    .dab_y       (dab_y),
    .dab_size    (dab_size),
    .dab_opacity (dab_opacity),
    .last_dab    (last_dab),
    .truncated   (truncated)
  );

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the brush dab spacer. A directed table of pen words
// runs first, then random strokes under several brush settings. Each dab word
// is compared field by field with an in-bench placement model or a table row.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  PHASES      = 8;
  localparam int  PER_PHASE   = 62;
  localparam int  DRAIN_WAIT  = 400;
  localparam longint CYCLE_LIMIT = 40000000;
  localparam logic MODE_BEGIN = 1'b0;
  localparam logic MODE_MOVE  = 1'b1;
  localparam logic [bds_pkg::IdxW-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] size;
    logic [7:0]  opac;
    logic        last;
    logic        trunc;
  } dab_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] x;
    logic [15:0] y;
    logic [8:0]  pres;
    logic        has_exp;
    dab_t        exp_dab;
  } pen_row_t;

  logic clk, rst;
  logic cfg_we;
  logic [bds_pkg::IdxW-1:0] cfg_index;
  logic [bds_pkg::CfgW-1:0] cfg_data;
  logic in_valid, in_stall, mode;
  logic [15:0] pen_x, pen_y;
  logic [8:0] pen_pressure;
  logic out_valid, out_stall;
  logic [15:0] dab_x, dab_y, dab_size;
  logic [7:0] dab_opacity;
  logic last_dab, truncated;

  brush_dab_spacer_unit uut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .mode, .pen_x, .pen_y, .pen_pressure,
    .out_valid, .out_stall, .dab_x, .dab_y, .dab_size, .dab_opacity,
    .last_dab, .truncated
  );

  // brush registers and stroke state of the model
  longint unsigned m_brush, m_frac, m_opac, m_taper, m_falloff, m_sbp, m_obp;
  longint unsigned m_lx, m_ly, m_left, m_trav;
  bit m_fresh;

  dab_t expected_dabs[$];
  int errors = 0;
  int words_sent = 0;
  int dabs_seen = 0;
  int trunc_seen = 0;
  bit calm = 0;
  longint cycles = 0;

  // directed pen words
  pen_row_t dir_tab [16] = '{
    '{MODE_MOVE,  16'd0,     16'd0,     9'd256, 1'b1, '{16'd0, 16'd0, 16'd160, 8'd255, 1'b1, 1'b0}},
    '{MODE_MOVE,  16'd0,     16'd0,     9'd256, 1'b0, '0},
    '{MODE_MOVE,  16'd40,    16'd0,     9'd256, 1'b0, '0},
    '{MODE_MOVE,  16'd40,    16'd0,     9'd256, 1'b0, '0},
    '{MODE_BEGIN, 16'd65535, 16'd65535, 9'd511, 1'b0, '0},
    '{MODE_MOVE,  16'd65535, 16'd65535, 9'd300, 1'b0, '0},
    '{MODE_MOVE,  16'd0,     16'd65535, 9'd511, 1'b0, '0},
    '{MODE_BEGIN, 16'd100,   16'd100,   9'd0,   1'b0, '0},
    '{MODE_MOVE,  16'd100,   16'd100,   9'd0,   1'b1, '{16'd100, 16'd100, 16'd0, 8'd255, 1'b1, 1'b0}},
    '{MODE_MOVE,  16'd100,   16'd100,   9'd0,   1'b0, '0},
    '{MODE_MOVE,  16'd200,   16'd300,   9'd128, 1'b0, '0},
    '{MODE_MOVE,  16'd0,     16'd0,     9'd1,   1'b0, '0},
    '{MODE_BEGIN, 16'd0,     16'd0,     9'd0,   1'b0, '0},
    '{MODE_MOVE,  16'd65535, 16'd65535, 9'd256, 1'b0, '0},
    '{MODE_MOVE,  16'd32768, 16'd32768, 9'd256, 1'b0, '0},
    '{MODE_MOVE,  16'd1,     16'd65534, 9'd255, 1'b0, '0}
  };

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // append one expected dab word
  task automatic queue_dab(input dab_t d);
    expected_dabs = {expected_dabs, d};
  endtask

  // rounded square root of the squared segment length
  function automatic longint unsigned seg_len(longint unsigned sq);
    longint unsigned r, t;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= sq) r = t;
    end
    if (sq - r * r > r) r = r + 1;
    return r;
  endfunction

  // point at distance c of d from a toward b, rounded to nearest, ties away from a
  function automatic longint unsigned lerp_pt(longint unsigned a, longint unsigned b,
                                              longint unsigned c, longint unsigned d);
    longint unsigned mag, q;
    if (d == 0) return a;
    mag = (b >= a) ? b - a : a - b;
    q = (2 * mag * c + d) / (2 * d);
    return (b >= a) ? a + q : a - q;
  endfunction

  // place the dabs of one pen word and, when keep is set, queue them
  task automatic place_dabs(input logic md, input logic [15:0] px, input logic [15:0] py,
                            input logic [8:0] pr, input bit keep);
    longint unsigned p, dx, dy, seg_dist, sz, op, spc, c0, n, emit, c, tot, ds, dop, clast;
    bit trunc;
    dab_t d;
    if (md == MODE_BEGIN) begin
      m_lx = px; m_ly = py; m_left = 0; m_trav = 0; m_fresh = 1;
      return;
    end
    p = (pr > 256) ? 256 : pr;
    dx = (px >= m_lx) ? px - m_lx : m_lx - px;
    dy = (py >= m_ly) ? py - m_ly : m_ly - py;
    seg_dist = seg_len(dx * dx + dy * dy);
    if (seg_dist == 0 && !m_fresh && m_left >= 2) return;
    sz = m_sbp ? (m_brush * p) >> 8 : m_brush;
    op = m_obp ? (m_opac * p) >> 8 : m_opac;
    if (op > 255) op = 255;
    spc = (sz * m_frac) >> 8;
    if (spc < 32) spc = 32;
    c0 = (m_fresh || m_left >= spc) ? 0 : spc - m_left;
    n = (c0 <= seg_dist) ? (seg_dist - c0) / spc + 1 : 0;
    trunc = n > 64;
    emit = trunc ? 64 : n;
    for (longint unsigned k = 0; k < emit; k++) begin
      c = c0 + k * spc;
      tot = m_trav + c;
      ds = sz;
      dop = op;
      if (m_taper > 0 && tot < m_taper) ds = (sz * tot) / m_taper;
      if (m_falloff > 0) dop = (tot < m_falloff) ? (op * (m_falloff - tot)) / m_falloff : 0;
      d.x = 16'(lerp_pt(m_lx, px, c, seg_dist));
      d.y = 16'(lerp_pt(m_ly, py, c, seg_dist));
      d.size = 16'(ds);
      d.opac = 8'(dop);
      d.last = (k + 1 == emit);
      d.trunc = trunc;
      if (keep) queue_dab(d);
    end
    if (n > 0) begin
      clast = c0 + (n - 1) * spc;
      m_left = (seg_dist - clast) & 18'h3FFFF;
    end else begin
      m_left = (m_left + seg_dist) & 18'h3FFFF;
    end
    m_trav = (m_trav + seg_dist > 64'hFFFFFFFF) ? 64'hFFFFFFFF : m_trav + seg_dist;
    m_fresh = 0;
    m_lx = px;
    m_ly = py;
  endtask

  task automatic cfg_write(input logic [bds_pkg::IdxW-1:0] idx, input longint unsigned val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= bds_pkg::CfgW'(val);
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    case (idx)
      bds_pkg::REG_BRUSH_SIZE:   m_brush = val & 16'hFFFF;
      bds_pkg::REG_SPACING_FRAC: m_frac = val & 10'h3FF;
      bds_pkg::REG_BASE_OPACITY: m_opac = val & 8'hFF;
      bds_pkg::REG_TAPER_LEN:    m_taper = val & 20'hFFFFF;
      bds_pkg::REG_FALLOFF_LEN:  m_falloff = val & 20'hFFFFF;
      bds_pkg::REG_SIZE_BY_PRES: m_sbp = val & 1;
      bds_pkg::REG_OPAC_BY_PRES: m_obp = val & 1;
      default: ;
    endcase
  endtask

  // drive one pen word and predict its dabs when it is taken
  task automatic send_pen(input pen_row_t w);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    mode <= w.mode;
    pen_x <= w.x;
    pen_y <= w.y;
    pen_pressure <= w.pres;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (w.has_exp) begin
      place_dabs(w.mode, w.x, w.y, w.pres, 0);
      queue_dab(w.exp_dab);
    end else begin
      place_dabs(w.mode, w.x, w.y, w.pres, 1);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (expected_dabs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // dab word receiver and checker
  initial begin
    int st;
    dab_t e;
    st = 0;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        dabs_seen++;
        if (truncated) trunc_seen++;
        if (expected_dabs.size() == 0) begin
          $display("%0t unexpected dab word x=%0d y=%0d", $time, dab_x, dab_y);
          errors++;
        end else begin
          e = expected_dabs.pop_front();
          if (dab_x !== e.x) begin
            $display("%0t dab_x exp %0d got %0d", $time, e.x, dab_x); errors++;
          end
          if (dab_y !== e.y) begin
            $display("%0t dab_y exp %0d got %0d", $time, e.y, dab_y); errors++;
          end
          if (dab_size !== e.size) begin
            $display("%0t dab_size exp %0d got %0d", $time, e.size, dab_size); errors++;
          end
          if (dab_opacity !== e.opac) begin
            $display("%0t dab_opacity exp %0d got %0d", $time, e.opac, dab_opacity); errors++;
          end
          if (last_dab !== e.last) begin
            $display("%0t last_dab exp %0d got %0d", $time, e.last, last_dab); errors++;
          end
          if (truncated !== e.trunc) begin
            $display("%0t truncated exp %0d got %0d", $time, e.trunc, truncated); errors++;
          end
        end
      end
      // receiver stall bursts
      if (st > 0) begin
        st--;
        out_stall <= 1;
      end else begin
        st = pick_gap();
        out_stall <= (st > 0);
        if (st > 0) st--;
      end
    end
  end

  // main sequence
  initial begin
    pen_row_t w;
    longint unsigned spc_est, reach;
    int cx, cy, nx, ny;
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 0;
    mode = 0;
    pen_x = 0;
    pen_y = 0;
    pen_pressure = 0;
    m_brush = 160; m_frac = 26; m_opac = 255; m_taper = 0; m_falloff = 0;
    m_sbp = 1; m_obp = 0;
    m_lx = 0; m_ly = 0; m_left = 0; m_trav = 0; m_fresh = 1;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed words at reset settings
    foreach (dir_tab[i]) send_pen(dir_tab[i]);

    cx = 0;
    cy = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      calm = (ph == 3);
      if (ph == 0) begin
        cfg_write(bds_pkg::REG_BRUSH_SIZE, 16);
        cfg_write(bds_pkg::REG_SPACING_FRAC, 0);
        cfg_write(bds_pkg::REG_BASE_OPACITY, 0);
        cfg_write(bds_pkg::REG_TAPER_LEN, 0);
        cfg_write(bds_pkg::REG_FALLOFF_LEN, 0);
        cfg_write(bds_pkg::REG_SIZE_BY_PRES, 0);
        cfg_write(bds_pkg::REG_OPAC_BY_PRES, 0);
      end else if (ph == 1) begin
        cfg_write(bds_pkg::REG_BRUSH_SIZE, 65535);
        cfg_write(bds_pkg::REG_SPACING_FRAC, 1023);
        cfg_write(bds_pkg::REG_BASE_OPACITY, 255);
        cfg_write(bds_pkg::REG_TAPER_LEN, 20'hFFFFF);
        cfg_write(bds_pkg::REG_FALLOFF_LEN, 20'hFFFFF);
        cfg_write(bds_pkg::REG_SIZE_BY_PRES, 1);
        cfg_write(bds_pkg::REG_OPAC_BY_PRES, 1);
      end else begin
        cfg_write(bds_pkg::REG_BRUSH_SIZE, ($urandom_range(0, 7) == 0) ?
                  $urandom_range(16, 65535) : $urandom_range(16, 600));
        cfg_write(bds_pkg::REG_SPACING_FRAC, $urandom_range(0, 1023));
        cfg_write(bds_pkg::REG_BASE_OPACITY, $urandom_range(0, 255));
        cfg_write(bds_pkg::REG_TAPER_LEN, ($urandom_range(0, 3) == 0) ? 0 :
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20'hFFFFF) :
                  $urandom_range(1, 4000));
        cfg_write(bds_pkg::REG_FALLOFF_LEN, ($urandom_range(0, 3) == 0) ? 0 :
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20'hFFFFF) :
                  $urandom_range(1, 8000));
        cfg_write(bds_pkg::REG_SIZE_BY_PRES, $urandom_range(0, 1));
        cfg_write(bds_pkg::REG_OPAC_BY_PRES, $urandom_range(0, 1));
      end
      // an index past the register list should be ignored
      if (ph == 2) cfg_write(REG_UNUSED, $urandom_range(0, 20'hFFFFF));

      spc_est = (m_brush * m_frac) >> 8;
      if (spc_est < 32) spc_est = 32;
      reach = spc_est * 6;
      if (reach > 4000) reach = 4000;

      for (int k = 0; k < PER_PHASE; k++) begin
        w = '0;
        w.pres = 9'(($urandom_range(0, 9) == 0) ? $urandom_range(257, 511) :
                    $urandom_range(0, 256));
        if (k == 0 || $urandom_range(0, 9) == 0) begin
          // stroke start
          w.mode = MODE_BEGIN;
          cx = $urandom_range(0, 65535);
          cy = $urandom_range(0, 65535);
        end else begin
          w.mode = MODE_MOVE;
          if ($urandom_range(0, 49) == 0) begin
            cx = $urandom_range(0, 65535);
            cy = $urandom_range(0, 65535);
          end else if ($urandom_range(0, 9) != 0) begin
            nx = cx + int'($urandom_range(0, int'(2 * reach))) - int'(reach);
            ny = cy + int'($urandom_range(0, int'(2 * reach))) - int'(reach);
            cx = (nx < 0) ? 0 : (nx > 65535) ? 65535 : nx;
            cy = (ny < 0) ? 0 : (ny > 65535) ? 65535 : ny;
          end
        end
        w.x = 16'(cx);
        w.y = 16'(cy);
        send_pen(w);
      end
    end

    // drain
    in_valid <= 0;
    while (expected_dabs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("run covered %0d pen words over %0d brush settings", words_sent, PHASES + 1);
    $display("checked %0d dab words, %0d from truncated segments", dabs_seen, trunc_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
